FILE: rtl/core/rtc_pkg.sv
`timescale 1ns / 1ps

package rtc_pkg;

  // Pixel component and curve word widths
  localparam int PIX_W     = 8;
  localparam int CURVE_W   = 32;
  localparam int PROD_W    = 2 * PIX_W;
  localparam int DIV_STEPS = PIX_W;
  localparam int CFG_ADDR_W = 3;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RED_CURVE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_CURVE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BLUE_CURVE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MASTER_CURVE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BYPASS       = 3'd4;

  // Curve (0,255)-(255,0): maps every x to itself
  localparam logic [CURVE_W-1:0] IDENT_CURVE = 32'h00FF_FF00;

  // Which branch of the curve rule an item takes
  typedef enum logic [1:0] {
    SEL_END    = 2'b00,
    SEL_START  = 2'b01,
    SEL_INTERP = 2'b10
  } rtc_sel_t;

  // Valid bit and side payload that ride along a curve pipeline
  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] side;
  } rtc_tag_t;

endpackage

FILE: rtl/core/rtc_curve.sv
`timescale 1ns / 1ps

// One two-point tone curve, 11 register stages:
// classify, multiply, eight restoring divide steps, final add.
module rtc_curve (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [rtc_pkg::CURVE_W-1:0]   curve,
  input  rtc_pkg::rtc_tag_t             in_tag,
  input  logic [rtc_pkg::PIX_W-1:0]     in_x,
  output rtc_pkg::rtc_tag_t             out_tag,
  output logic [rtc_pkg::PIX_W-1:0]     out_y
);
  import rtc_pkg::*;

  // Curve points; the user must keep them stable while items are in flight (not enforced here)
  logic [PIX_W-1:0] sx, sy, ex, ey;
  logic [PIX_W-1:0] dvsr, mag, base_y, alt_y;
  logic             neg;

  assign sx     = curve[PIX_W-1:0];
  assign sy     = curve[2*PIX_W-1:PIX_W];
  assign ex     = curve[3*PIX_W-1:2*PIX_W];
  assign ey     = curve[4*PIX_W-1:3*PIX_W];
  assign dvsr   = ex - sx;
  assign neg    = (sy < ey);
  assign mag    = neg ? (ey - sy) : (sy - ey);
  assign base_y = ~sy;
  assign alt_y  = ~ey;

  // Stage A: pick the branch, offset from start x
  rtc_tag_t         a_tag_r;
  rtc_sel_t         a_sel_r, a_sel_nxt;
  logic [PIX_W-1:0] a_n_r;

  always_comb begin
    if (in_x >= ex) begin
      a_sel_nxt = SEL_END;
    end else if (in_x < sx) begin
      a_sel_nxt = SEL_START;
    end else begin
      a_sel_nxt = SEL_INTERP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
    end else if (en) begin
      a_tag_r <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sel_r <= a_sel_nxt;
      a_n_r   <= in_x - sx;
    end
  end

  // Stage B and divide steps share one set of arrays; index 0 holds the product
  rtc_tag_t          dv_tag_r [0:DIV_STEPS];
  rtc_sel_t          dv_sel_r [0:DIV_STEPS];
  logic [PROD_W-1:0] dv_rem_r [0:DIV_STEPS];
  logic [PIX_W-1:0]  dv_q_r   [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_tag_r[0] <= '0;
    end else if (en) begin
      dv_tag_r[0] <= a_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sel_r[0] <= a_sel_r;
      dv_rem_r[0] <= {{PIX_W{1'b0}}, a_n_r} * {{PIX_W{1'b0}}, mag};
      dv_q_r[0]   <= '0;
    end
  end

  // Restoring divide: for interpolated items the quotient does not exceed mag, so it fits in PIX_W bits
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int QB = DIV_STEPS - 1 - k;
    logic [PROD_W-1:0] dsh;
    logic              ge;
    logic [PROD_W-1:0] rem_nxt;
    logic [PIX_W-1:0]  q_nxt;

    assign dsh = {{PIX_W{1'b0}}, dvsr} << QB;
    assign ge  = (dv_rem_r[k] >= dsh);

    always_comb begin
      rem_nxt   = ge ? (dv_rem_r[k] - dsh) : dv_rem_r[k];
      q_nxt     = dv_q_r[k];
      q_nxt[QB] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_tag_r[k+1] <= '0;
      end else if (en) begin
        dv_tag_r[k+1] <= dv_tag_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sel_r[k+1] <= dv_sel_r[k];
        dv_rem_r[k+1] <= rem_nxt;
        dv_q_r[k+1]   <= q_nxt;
      end
    end
  end

  // Final stage: select branch, apply signed slope term
  rtc_tag_t         y_tag_r;
  logic [PIX_W-1:0] y_r, y_nxt;
  logic [PIX_W-1:0] q_fin;

  assign q_fin = dv_q_r[DIV_STEPS];

  always_comb begin
    case (dv_sel_r[DIV_STEPS])
      SEL_END:    y_nxt = alt_y;
      SEL_START:  y_nxt = base_y;
      SEL_INTERP: y_nxt = neg ? (base_y - q_fin) : (base_y + q_fin);
      default:    y_nxt = alt_y;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_tag_r <= '0;
    end else if (en) begin
      y_tag_r <= dv_tag_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

  assign out_tag = y_tag_r;
  assign out_y   = y_r;

`ifndef ASSERT_OFF
  // Interpolated quotient never exceeds the y span
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_tag_r[DIV_STEPS].vld && (dv_sel_r[DIV_STEPS] == SEL_INTERP)) |-> (q_fin <= mag))
    else $error("rtc_curve: quotient above y span");

  // Output lies between the two end levels
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    y_tag_r.vld |-> ((y_r >= base_y && y_r <= alt_y) || (y_r >= alt_y && y_r <= base_y)))
    else $error("rtc_curve: output outside curve range");
`endif

endmodule

FILE: rtl/core/rgb_tone_curve_pixel_map.sv
`timescale 1ns / 1ps

// RGBA tone curve pixel map.
// Input stream in_*: one RGBA pixel per transfer, tdata = {alpha, blue, green, red}.
// Output stream out_*: the mapped pixel in the same packing. Red, green and blue
// each pass their own two-point curve and then the master curve; alpha is copied.
// Configuration: cfg_we/cfg_addr/cfg_wdata write registers 0..4 (red, green,
// blue, master curve, bypass); write them only while the block is empty.
// Bypass swaps every curve for the identity curve.
// Pipeline: two curves in series, 11 register stages each: classify, multiply,
// eight restoring divide steps, final add.
// Throughput: one pixel per cycle when not stalled; the eight-step divider is fully pipelined.
// Stall: the whole pipeline holds while out_tvalid is high and out_tready low;
// in_tready is low only then, and bubbles in flight move forward otherwise.
// Reset (rst_n low, synchronous): all valid bits clear, curves return to the
// identity curve and bypass clears.
module rgb_tone_curve_pixel_map (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,  // red_in, green_in, blue_in, alpha_in
  // Output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata, // red_out, green_out, blue_out, alpha_out
  // Configuration writes
  input  logic                              cfg_we,
  input  logic [rtc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rtc_pkg::CURVE_W-1:0]       cfg_wdata
);
  import rtc_pkg::*;

  // Configuration registers
  logic [CURVE_W-1:0] red_curve_r, green_curve_r, blue_curve_r, master_curve_r;
  logic               bypass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_curve_r    <= IDENT_CURVE;
      green_curve_r  <= IDENT_CURVE;
      blue_curve_r   <= IDENT_CURVE;
      master_curve_r <= IDENT_CURVE;
      bypass_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RED_CURVE:    red_curve_r    <= cfg_wdata;
        REG_GREEN_CURVE:  green_curve_r  <= cfg_wdata;
        REG_BLUE_CURVE:   blue_curve_r   <= cfg_wdata;
        REG_MASTER_CURVE: master_curve_r <= cfg_wdata;
        REG_BYPASS:       bypass_r       <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // Bypass runs every curve as identity
  logic [CURVE_W-1:0] red_eff, green_eff, blue_eff, master_eff;

  assign red_eff    = bypass_r ? IDENT_CURVE : red_curve_r;
  assign green_eff  = bypass_r ? IDENT_CURVE : green_curve_r;
  assign blue_eff   = bypass_r ? IDENT_CURVE : blue_curve_r;
  assign master_eff = bypass_r ? IDENT_CURVE : master_curve_r;

  // Global advance: move when the output register is free or being taken
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Input unpacking; alpha rides as side payload of the red lane
  rtc_tag_t tag_in_a, tag_in_z;
  assign tag_in_a = '{vld: in_tvalid, side: in_tdata[4*PIX_W-1:3*PIX_W]};
  assign tag_in_z = '{vld: in_tvalid, side: '0};

  rtc_tag_t         r_tag, g_tag, b_tag, rm_tag, gm_tag, bm_tag;
  logic [PIX_W-1:0] r_y, g_y, b_y, rm_y, gm_y, bm_y;

  // Channel curves
  rtc_curve u_red (
    .clk(clk), .rst_n(rst_n), .en(en), .curve(red_eff),
    .in_tag(tag_in_a), .in_x(in_tdata[PIX_W-1:0]), .out_tag(r_tag), .out_y(r_y)
  );
  rtc_curve u_green (
    .clk(clk), .rst_n(rst_n), .en(en), .curve(green_eff),
    .in_tag(tag_in_z), .in_x(in_tdata[2*PIX_W-1:PIX_W]), .out_tag(g_tag), .out_y(g_y)
  );
  rtc_curve u_blue (
    .clk(clk), .rst_n(rst_n), .en(en), .curve(blue_eff),
    .in_tag(tag_in_z), .in_x(in_tdata[3*PIX_W-1:2*PIX_W]), .out_tag(b_tag), .out_y(b_y)
  );

  // Master curve on each channel
  rtc_curve u_red_m (
    .clk(clk), .rst_n(rst_n), .en(en), .curve(master_eff),
    .in_tag(r_tag), .in_x(r_y), .out_tag(rm_tag), .out_y(rm_y)
  );
  rtc_curve u_green_m (
    .clk(clk), .rst_n(rst_n), .en(en), .curve(master_eff),
    .in_tag(g_tag), .in_x(g_y), .out_tag(gm_tag), .out_y(gm_y)
  );
  rtc_curve u_blue_m (
    .clk(clk), .rst_n(rst_n), .en(en), .curve(master_eff),
    .in_tag(b_tag), .in_x(b_y), .out_tag(bm_tag), .out_y(bm_y)
  );

  // Output packing; last master stage is the output register
  assign out_tvalid = rm_tag.vld;
  assign out_tdata  = {rm_tag.side, bm_y, gm_y, rm_y};

`ifndef ASSERT_OFF
  // The three lanes stay in lockstep
  a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (rm_tag.vld == gm_tag.vld) && (rm_tag.vld == bm_tag.vld)
    && (r_tag.vld == g_tag.vld) && (r_tag.vld == b_tag.vld))
    else $error("rgb_tone_curve_pixel_map: lane valid bits diverge");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("rgb_tone_curve_pixel_map: output valid after reset");
`endif

endmodule

FILE: tb/sv/rgb_tone_curve_pixel_map_tb.sv
`timescale 1ns / 1ps

module rgb_tone_curve_pixel_map_tb;
  import rtc_pkg::*;

  localparam int RANDOM_PHASES  = 12;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 30;
  localparam int SPARE_REGS     = (1 << CFG_ADDR_W) - REG_BYPASS - 1;

  // Pixel as it travels in tdata, red in the lowest byte
  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgba_t;

  // Scoreboard: own copy of the curve registers, expected pixels in order
  class tone_curve_checker;
    logic [CURVE_W-1:0] red_pts, green_pts, blue_pts, master_pts;
    logic               pass_through;
    rgba_t              mapped_pixels[$];
    int                 pixel_mismatches;

    function new();
      red_pts          = IDENT_CURVE;
      green_pts        = IDENT_CURVE;
      blue_pts         = IDENT_CURVE;
      master_pts       = IDENT_CURVE;
      pass_through     = 1'b0;
      pixel_mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CURVE_W-1:0] val);
      case (idx)
        REG_RED_CURVE:    red_pts = val;
        REG_GREEN_CURVE:  green_pts = val;
        REG_BLUE_CURVE:   blue_pts = val;
        REG_MASTER_CURVE: master_pts = val;
        REG_BYPASS:       pass_through = val[0];
        default: ;
      endcase
    endfunction

    // Two-point curve; the end-point case takes priority over the start case
    function logic [PIX_W-1:0] tone(logic [CURVE_W-1:0] pts, logic [PIX_W-1:0] x);
      int sx, sy, ex, ey, xi, r;
      sx = int'(pts[7:0]);
      sy = int'(pts[15:8]);
      ex = int'(pts[23:16]);
      ey = int'(pts[31:24]);
      xi = int'(x);
      if (xi >= ex) begin
        r = 255 - ey;
      end else if (xi < sx) begin
        r = 255 - sy;
      end else begin
        // int division truncates toward zero, also for a negative product
        r = 255 - sy + ((xi - sx) * (sy - ey)) / (ex - sx);
      end
      return r[PIX_W-1:0];
    endfunction

    function rgba_t map_pixel(rgba_t px);
      rgba_t res;
      res = px;
      if (!pass_through) begin
        res.red   = tone(master_pts, tone(red_pts, px.red));
        res.green = tone(master_pts, tone(green_pts, px.green));
        res.blue  = tone(master_pts, tone(blue_pts, px.blue));
      end
      return res;
    endfunction

    function void note_pixel(rgba_t px);
      mapped_pixels.push_back(map_pixel(px));
    endfunction

    function void match_component(string name, logic [PIX_W-1:0] exp_v,
                                  logic [PIX_W-1:0] got_v);
      if (got_v !== exp_v) begin
        pixel_mismatches++;
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_pixel(rgba_t got);
      rgba_t exp_px;
      if (mapped_pixels.size() == 0) begin
        pixel_mismatches++;
        $display("%0t: unexpected output transfer, expected none, actual %08h", $time, got);
      end else begin
        exp_px = mapped_pixels.pop_front();
        match_component("red", exp_px.red, got.red);
        match_component("green", exp_px.green, got.green);
        match_component("blue", exp_px.blue, got.blue);
        match_component("alpha", exp_px.alpha, got.alpha);
      end
    endfunction

    function int pending();
      return mapped_pixels.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CURVE_W-1:0]    cfg_wdata = '0;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_off_request = 1'b0;

  tone_curve_checker curve_check = new();

  rgb_tone_curve_pixel_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Curve word {ey, ex, sy, sx}, extremes and degenerate shapes included
  function automatic logic [CURVE_W-1:0] pick_curve();
    logic [7:0] sx, sy, ex, ey;
    sy = 8'($urandom_range(0, 255));
    ey = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return IDENT_CURVE;
      1: return '0;
      2: return '1;
      3: begin
        // start at or past end: no interpolation range
        sx = 8'($urandom_range(0, 255));
        ex = 8'($urandom_range(0, sx));
      end
      4, 5: begin
        ex = 8'($urandom_range(1, 255));
        sx = 8'($urandom_range(0, ex - 1));
      end
      default: return $urandom();
    endcase
    return {ey, ex, sy, sx};
  endfunction

  // Component near a curve break point, or anywhere
  function automatic logic [PIX_W-1:0] pick_component(logic [CURVE_W-1:0] pts);
    case ($urandom_range(0, 5))
      0: return pts[7:0];
      1: return pts[23:16];
      2: return pts[7:0] - 8'd1;
      3: return pts[23:16] - 8'd1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      curve_check.check_pixel(out_tdata);
    end
  end

  // Receiver pacing, with one long hold-off on request
  initial begin : sink_pacing
    int run_len, gap;
    forever begin
      if (hold_off_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_request = 1'b0;
      end
      out_tready <= 1'b1;
      run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      gap = rx_steady ? 0 : pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // One input transfer; in_tvalid stays high for a back-to-back pixel
  task automatic send_pixel(input rgba_t px);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    curve_check.note_pixel(px);
  endtask

  // Stop offering and let every expected pixel come out
  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    while (curve_check.pending() != 0) @(posedge clk);
  endtask

  // Writes all five registers back to back, then some ignored indexes
  task automatic program_curves(input logic [CURVE_W-1:0] r, g, b, m, byp,
                                input int spares);
    logic [CFG_ADDR_W-1:0] idx;
    logic [CURVE_W-1:0]    val;
    for (int k = 0; k < 5 + spares; k++) begin
      case (k)
        0: begin idx = REG_RED_CURVE;    val = r;   end
        1: begin idx = REG_GREEN_CURVE;  val = g;   end
        2: begin idx = REG_BLUE_CURVE;   val = b;   end
        3: begin idx = REG_MASTER_CURVE; val = m;   end
        4: begin idx = REG_BYPASS;       val = byp; end
        default: begin
          idx = CFG_ADDR_W'(REG_BYPASS + 1 + (k - 5) % SPARE_REGS);
          val = $urandom();
        end
      endcase
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= val;
      @(posedge clk);
      curve_check.write_reg(idx, val);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CURVE_W-1:0] r_pts, g_pts, b_pts, m_pts, byp_word;
    rgba_t              px;
    int                 burst;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset curves: identity on every channel
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h55AA_807F);
    send_pixel(32'hAA55_7F80);
    drain_pixels();

    // Falling, rising, start-past-end and zero-width master curve;
    // bypass word with only high bits set reads as bypass off
    program_curves(32'h0AC8_E628, 32'hF0FA_140A, 32'h2164_4DC8, 32'hFA80_0580,
                   32'hFFFF_FFFE, SPARE_REGS);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFF63_0927);
    send_pixel(32'h0164_0A28);
    send_pixel(32'h80C7_F9C7);
    send_pixel(32'h7FC8_FAC8);
    send_pixel(32'hFEFF_FFFF);
    repeat (3) send_pixel($urandom());
    drain_pixels();

    // Bypass on
    program_curves(32'h0AC8_E628, 32'hF0FA_140A, 32'h2164_4DC8, 32'hFA80_0580,
                   32'h5A5A_5A5B, 0);
    send_pixel(32'h1234_5678);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    drain_pixels();

    // Random settings, each followed by a burst of pixels
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      r_pts    = pick_curve();
      g_pts    = pick_curve();
      b_pts    = pick_curve();
      m_pts    = pick_curve();
      byp_word = $urandom();
      byp_word[0] = ($urandom_range(0, 3) == 0);
      program_curves(r_pts, g_pts, b_pts, m_pts, byp_word, $urandom_range(0, 3));

      if (ph == 1) begin
        // fill the pipeline against a stalled receiver
        tx_steady        = 1'b1;
        rx_steady        = 1'b0;
        hold_off_request = 1'b1;
        burst            = 80;
      end else begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        burst     = $urandom_range(40, 85);
      end

      for (int n = 0; n < burst; n++) begin
        px = $urandom();
        if ($urandom_range(0, 1) == 0) begin
          px.red   = pick_component(r_pts);
          px.green = pick_component(g_pts);
          px.blue  = pick_component(b_pts);
        end
        send_pixel(px);
      end
      drain_pixels();
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (curve_check.pixel_mismatches == 0) begin
      $display("rgb_tone_curve_pixel_map_tb: done, clean");
    end else begin
      $display("rgb_tone_curve_pixel_map_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #3_000_000;
    $display("rgb_tone_curve_pixel_map_tb: done, errors");
    $finish;
  end

endmodule

FILE: rgb_tone_curve_pixel_map.f
rtl/core/rtc_pkg.sv
rtl/core/rtc_curve.sv
rtl/core/rgb_tone_curve_pixel_map.sv
tb/sv/rgb_tone_curve_pixel_map_tb.sv
